// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: src/bpc_pkg.sv
// Shared types and constants of the barometer pressure compensation block.
package bpc_pkg;

   localparam int NUM_STAGES = 9;

   // csr register indexes
   localparam logic [2:0] CSR_A0  = 3'd0;
   localparam logic [2:0] CSR_B1  = 3'd1;
   localparam logic [2:0] CSR_B2  = 3'd2;
   localparam logic [2:0] CSR_C12 = 3'd3;
   localparam logic [2:0] CSR_C11 = 3'd4;
   localparam logic [2:0] CSR_C22 = 3'd5;

   // temperature: 6400 - round((tadc - 472) * 5120 / 107)
   localparam logic signed [10:0] T_OFFSET = 11'sd472;
   localparam logic signed [15:0] T_BASE   = 16'sd6400;
   localparam logic [21:0]        T_ROUND  = 22'd53;
   localparam int                 T_SHIFT  = 29;
   localparam logic [22:0]        T_RECIP  = 23'((2**T_SHIFT + 106) / 107);

   // pressure: 12800 + (c * 16640 + 511) / 1023
   localparam logic [14:0] KPA_BASE  = 15'd12800;
   localparam logic [24:0] KPA_ROUND = 25'd511;
   localparam int          K_SHIFT   = 35;
   localparam logic [25:0] K_RECIP   = 26'(((64'd1 << K_SHIFT) + 64'd1022) / 64'd1023);

   typedef struct packed {
      logic signed [15:0] a0;
      logic signed [15:0] b1;
      logic signed [15:0] b2;
      logic signed [15:0] c12;
      logic signed [15:0] c11;
      logic signed [15:0] c22;
   } coef_type;

endpackage

// File: src/bpc_dpath.sv
// Nine-stage datapath: compensation polynomial and unit conversions.
module bpc_dpath (
   input  logic                              clock,
   input  logic [bpc_pkg::NUM_STAGES-1:0]    ld,
   input  logic [15:0]                       pressure_word,
   input  logic [15:0]                       temperature_word,
   input  bpc_pkg::coef_type                 coef,
   output logic signed [18:0]                compensated_count,
   output logic [14:0]                       pressure_kpa_q8,
   output logic signed [15:0]                temperature_c_q8
);

   // stage 1
   logic [9:0]         padc1_ff, padc1_in, tadc1_ff, tadc1_in;
   logic signed [26:0] c11x1_1_ff, c11x1_1_in;
   logic signed [26:0] c12x2_1_ff, c12x2_1_in;
   logic signed [26:0] c22x2_1_ff, c22x2_1_in;
   logic [21:0]        tmag1_ff, tmag1_in;
   logic               tneg1_ff, tneg1_in;
   // stage 2
   logic [9:0]         padc2_ff, tadc2_ff;
   logic signed [26:0] c12x2_2_ff;
   logic signed [17:0] a11_2_ff, a11_2_in;
   logic signed [15:0] a2_2_ff, a2_2_in;
   logic [44:0]        tprod2_ff, tprod2_in;
   logic               tneg2_ff;
   // stage 3
   logic [9:0]         padc3_ff, tadc3_ff;
   logic signed [20:0] a1_3_ff, a1_3_in;
   logic signed [15:0] a2_3_ff;
   logic signed [15:0] temp3_ff, temp3_in;
   // stage 4
   logic signed [31:0] a1x1_4_ff, a1x1_4_in;
   logic signed [26:0] a2x2_4_ff, a2x2_4_in;
   logic signed [15:0] temp4_ff;
   // stage 5
   logic signed [21:0] y1_5_ff, y1_5_in;
   logic signed [26:0] a2x2_5_ff;
   logic signed [15:0] temp5_ff;
   // stage 6
   logic signed [18:0] pc6_ff, pc6_in;
   logic signed [15:0] temp6_ff;
   // stage 7
   logic signed [18:0] pc7_ff;
   logic [24:0]        kn7_ff, kn7_in;
   logic signed [15:0] temp7_ff;
   // stage 8
   logic signed [18:0] pc8_ff;
   logic [50:0]        kprod8_ff, kprod8_in;
   logic signed [15:0] temp8_ff;
   // stage 9
   logic signed [18:0] pc9_ff;
   logic [14:0]        kpa9_ff, kpa9_in;
   logic signed [15:0] temp9_ff;

   always_comb begin
      logic signed [10:0] d;
      logic signed [22:0] n;
      logic [22:0]        nabs;
      logic signed [31:0] s11, s2, s1, sy, sum, adj;
      logic [15:0]        tq;
      logic [9:0]         clamped;

      // stage 1: counts, raw products, temperature magnitude
      padc1_in   = pressure_word[15:6];
      tadc1_in   = temperature_word[15:6];
      c11x1_1_in = coef.c11 * signed'({1'b0, padc1_in});
      c12x2_1_in = coef.c12 * signed'({1'b0, tadc1_in});
      c22x2_1_in = coef.c22 * signed'({1'b0, tadc1_in});
      d          = signed'({1'b0, tadc1_in}) - bpc_pkg::T_OFFSET;
      n          = (23'(d) <<< 12) + (23'(d) <<< 10);
      nabs       = n[22] ? 23'(-n) : 23'(n);
      tneg1_in   = n[22];
      tmag1_in   = 22'(nabs) + bpc_pkg::T_ROUND;

      // stage 2: a11, a2, reciprocal product for /107
      s11       = (32'(coef.b1) <<< 14) + 32'(c11x1_1_ff);
      a11_2_in  = s11[31:14];
      s2        = (32'(coef.b2) <<< 15) + (32'(c22x2_1_ff) >>> 1);
      a2_2_in   = s2[31:16];
      tprod2_in = tmag1_ff * bpc_pkg::T_RECIP;

      // stage 3: a1, temperature result
      s1       = (32'(a11_2_ff) <<< 11) + 32'(c12x2_2_ff);
      a1_3_in  = s1[31:11];
      tq       = tprod2_ff[bpc_pkg::T_SHIFT+15:bpc_pkg::T_SHIFT];
      temp3_in = tneg2_ff ? (bpc_pkg::T_BASE + signed'(tq)) :
                            (bpc_pkg::T_BASE - signed'(tq));

      // stage 4: second-level products
      a1x1_4_in = a1_3_ff * signed'({1'b0, padc3_ff});
      a2x2_4_in = a2_3_ff * signed'({1'b0, tadc3_ff});

      // stage 5: y1
      sy      = (32'(coef.a0) <<< 10) + a1x1_4_ff;
      y1_5_in = sy[31:10];

      // stage 6: final sum, divide by 8192 toward zero
      sum    = (32'(y1_5_ff) <<< 10) + 32'(a2x2_5_ff);
      adj    = sum + (sum[31] ? 32'sd8191 : 32'sd0);
      pc6_in = adj[31:13];

      // stage 7: clamp and scale numerator
      if (pc6_ff[18]) begin
         clamped = 10'd0;
      end else if (pc6_ff > 19'sd1023) begin
         clamped = 10'd1023;
      end else begin
         clamped = pc6_ff[9:0];
      end
      kn7_in = (25'(clamped) << 14) + (25'(clamped) << 8) + bpc_pkg::KPA_ROUND;

      // stage 8: reciprocal product for /1023
      kprod8_in = kn7_ff * bpc_pkg::K_RECIP;

      // stage 9
      kpa9_in = 15'(kprod8_ff[bpc_pkg::K_SHIFT+15:bpc_pkg::K_SHIFT]) + bpc_pkg::KPA_BASE;
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         padc1_ff   <= padc1_in;
         tadc1_ff   <= tadc1_in;
         c11x1_1_ff <= c11x1_1_in;
         c12x2_1_ff <= c12x2_1_in;
         c22x2_1_ff <= c22x2_1_in;
         tmag1_ff   <= tmag1_in;
         tneg1_ff   <= tneg1_in;
      end
      if (ld[1]) begin
         padc2_ff   <= padc1_ff;
         tadc2_ff   <= tadc1_ff;
         c12x2_2_ff <= c12x2_1_ff;
         a11_2_ff   <= a11_2_in;
         a2_2_ff    <= a2_2_in;
         tprod2_ff  <= tprod2_in;
         tneg2_ff   <= tneg1_ff;
      end
      if (ld[2]) begin
         padc3_ff <= padc2_ff;
         tadc3_ff <= tadc2_ff;
         a1_3_ff  <= a1_3_in;
         a2_3_ff  <= a2_2_ff;
         temp3_ff <= temp3_in;
      end
      if (ld[3]) begin
         a1x1_4_ff <= a1x1_4_in;
         a2x2_4_ff <= a2x2_4_in;
         temp4_ff  <= temp3_ff;
      end
      if (ld[4]) begin
         y1_5_ff   <= y1_5_in;
         a2x2_5_ff <= a2x2_4_ff;
         temp5_ff  <= temp4_ff;
      end
      if (ld[5]) begin
         pc6_ff   <= pc6_in;
         temp6_ff <= temp5_ff;
      end
      if (ld[6]) begin
         pc7_ff   <= pc6_ff;
         kn7_ff   <= kn7_in;
         temp7_ff <= temp6_ff;
      end
      if (ld[7]) begin
         pc8_ff    <= pc7_ff;
         kprod8_ff <= kprod8_in;
         temp8_ff  <= temp7_ff;
      end
      if (ld[8]) begin
         pc9_ff   <= pc8_ff;
         kpa9_ff  <= kpa9_in;
         temp9_ff <= temp8_ff;
      end
   end

   assign compensated_count = pc9_ff;
   assign pressure_kpa_q8   = kpa9_ff;
   assign temperature_c_q8  = temp9_ff;

endmodule

// File: src/barometer_pressure_compensation.sv
// Top level: coefficient registers, pipeline flow control and the datapath.
//
//   channel  | dir | handshake             | payload
//   req      | in  | req_tvalid/req_tready | pressure_word, temperature_word
//   rsp      | out | rsp_tvalid/rsp_tready | compensated_count, kPa Q7.8, degC Q8.8
//   csr      | in  | csr_wen               | csr_index, csr_wdata
//
// One request per cycle while the output is not stalled; the datapath has nine
// register stages (each multiplier is followed by a register).
// Reset (synchronous) empties the pipeline and clears all coefficients.
// Each stage holds its item while the stage after it is full and stalled;
// bubbles are squeezed out, so a stalled output still lets earlier stages fill.
`include "assert_macros.svh"

module barometer_pressure_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] pressure_word, [31:16] temperature_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [18:0] compensated_count, [33:19] pressure_kpa_q8,
                                    // [49:34] temperature_c_q8, [55:50] zero
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int NS = bpc_pkg::NUM_STAGES;

   bpc_pkg::coef_type coef_ff, coef_in;
   logic [NS-1:0]     vld_ff, vld_in;
   logic [NS:0]       rdy;

   logic signed [18:0] compensated_count;
   logic [14:0]        pressure_kpa_q8;
   logic signed [15:0] temperature_c_q8;

   always_comb begin
      coef_in = coef_ff;
      if (csr_wen) begin
         case (csr_index)
            bpc_pkg::CSR_A0:  coef_in.a0  = signed'(csr_wdata);
            bpc_pkg::CSR_B1:  coef_in.b1  = signed'(csr_wdata);
            bpc_pkg::CSR_B2:  coef_in.b2  = signed'(csr_wdata);
            bpc_pkg::CSR_C12: coef_in.c12 = signed'(csr_wdata);
            bpc_pkg::CSR_C11: coef_in.c11 = signed'(csr_wdata);
            bpc_pkg::CSR_C22: coef_in.c22 = signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   // a stage may load when empty or when the next one loads too
   always_comb begin
      rdy[NS] = rsp_tready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      for (int k = 0; k < NS; k++) begin
         if (rdy[k]) begin
            vld_in[k] = (k == 0) ? req_tvalid : vld_ff[(k == 0) ? 0 : k - 1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
         vld_ff  <= '0;
      end else begin
         coef_ff <= coef_in;
         vld_ff  <= vld_in;
      end
   end

   bpc_dpath u_dpath (
      .clock             (clock),
      .ld                (rdy[NS-1:0]),
      .pressure_word     (req_tdata[15:0]),
      .temperature_word  (req_tdata[31:16]),
      .coef              (coef_ff),
      .compensated_count (compensated_count),
      .pressure_kpa_q8   (pressure_kpa_q8),
      .temperature_c_q8  (temperature_c_q8)
   );

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = {6'b0, temperature_c_q8, pressure_kpa_q8, compensated_count};

   `ASSERT_HOLDS(a_accept_enters, clock, reset, (req_tvalid && req_tready) |=> vld_ff[0], "accepted request did not enter the first stage")
   `ASSERT_NEVER(a_empty_stalls, clock, reset, (vld_ff == '0) && !req_tready, "empty pipeline refused a request")
   `ASSERT_NEVER(a_kpa_range, clock, reset, rsp_tvalid && (pressure_kpa_q8 < 15'd12800 || pressure_kpa_q8 > 15'd29440), "pressure outside 12800..29440")
   `ASSERT_NEVER(a_temp_range, clock, reset, rsp_tvalid && (temperature_c_q8 < -16'sd19966 || temperature_c_q8 > 16'sd28986), "temperature outside -19966..28986")

endmodule
